### hdl/cc20_pkg.sv
// Shared types, constants and quarter-round function for the ChaCha20 cipher block.
`default_nettype none
package cc20_pkg;

  localparam int unsigned NUM_WORDS  = 16;
  localparam int unsigned NUM_ROUNDS = 20;

  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_0_7    = 3'd0;
  localparam logic [2:0] REG_KEY_8_15   = 3'd1;
  localparam logic [2:0] REG_KEY_16_23  = 3'd2;
  localparam logic [2:0] REG_KEY_24_31  = 3'd3;
  localparam logic [2:0] REG_NONCE_0_7  = 3'd4;
  localparam logic [2:0] REG_NONCE_8_11 = 3'd5;
  localparam logic [2:0] REG_INIT_CTR   = 3'd6;

  typedef logic [NUM_WORDS-1:0][31:0] cc_state_t;
  typedef logic [3:0][31:0] qr_words_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } cc_fsm_t;

  // One quarter round: words in order a, b, c, d.
  function automatic qr_words_t quarter_round(input qr_words_t q);
    logic [31:0] a, b, c, d;
    qr_words_t r;
    a = q[0]; b = q[1]; c = q[2]; d = q[3];
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    r[0] = a; r[1] = b; r[2] = c; r[3] = d;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/cc20_round.sv
// One ChaCha20 round: four quarter rounds over columns or diagonals.
`default_nettype none
module cc20_round (
  input  wire cc20_pkg::cc_state_t w_in,
  input  wire                      diag,
  output cc20_pkg::cc_state_t      w_out
);

  always_comb begin
    cc20_pkg::qr_words_t q;
    cc20_pkg::qr_words_t r;
    w_out = w_in;
    for (int i = 0; i < 4; i++) begin
      if (diag) begin
        q[0] = w_in[i];
        q[1] = w_in[4 + ((i + 1) % 4)];
        q[2] = w_in[8 + ((i + 2) % 4)];
        q[3] = w_in[12 + ((i + 3) % 4)];
      end else begin
        q[0] = w_in[i];
        q[1] = w_in[4 + i];
        q[2] = w_in[8 + i];
        q[3] = w_in[12 + i];
      end
      r = cc20_pkg::quarter_round(q);
      if (diag) begin
        w_out[i]                  = r[0];
        w_out[4 + ((i + 1) % 4)]  = r[1];
        w_out[8 + ((i + 2) % 4)]  = r[2];
        w_out[12 + ((i + 3) % 4)] = r[3];
      end else begin
        w_out[i]      = r[0];
        w_out[4 + i]  = r[1];
        w_out[8 + i]  = r[2];
        w_out[12 + i] = r[3];
      end
    end
  end

endmodule
`default_nettype wire

### hdl/chacha20_stream_cipher_top.sv
// Top level of the ChaCha20 stream cipher: sequencer, state, output register.
`default_nettype none
// ChaCha20 (20 rounds, 96-bit nonce, 32-bit block counter) working on items of
// eight little-endian message bytes. Write key, nonce and initial counter over
// the cfg port while the block is idle. An item with start_req reloads the
// block counter and begins a fresh 64-byte keystream block; an item with
// last_item ends the block, so the next item draws on a new block with the
// counter just advanced. Each item consumes one 64-bit keystream word. An item
// that opens a block passes through accept, then one round per cycle through a
// single shared round unit, the feed-forward add and emit. Every other item
// passes through accept and emit only. in_stall is high while an item is at
// work; the result sits in an output register until taken, and the next item
// is accepted as soon as the result is loaded there. Output bytes at or beyond
// byte_count are zero.
module chacha20_stream_cipher_top (
  input  wire         clk,
  input  wire         rst,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [63:0] data_in,
  input  wire  [3:0]  byte_count,
  input  wire         last_item,
  input  wire         start_req,
  input  wire         keystream_only,
  // output channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] data_out,
  output logic [3:0]  byte_count_out,
  output logic        last_out,
  // configuration
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_data
);

  // configuration registers
  logic [3:0][63:0] key;
  logic [63:0]      nonce_lo;
  logic [31:0]      nonce_hi;
  logic [31:0]      init_ctr;

  // block state
  cc20_pkg::cc_fsm_t   state, state_next;
  cc20_pkg::cc_state_t w;          // working state, then keystream buffer
  cc20_pkg::cc_state_t w_round;
  cc20_pkg::cc_state_t init_words;
  logic [31:0] counter;
  logic [2:0]  pos;
  logic [4:0]  round_cnt;

  // held item
  logic [63:0] item_data;
  logic [3:0]  item_count;
  logic        item_last;
  logic        item_ks_only;

  logic        in_fire;
  logic        out_fire;
  logic        emit_fire;
  logic        need_block;
  logic [31:0] ctr_word;
  logic [63:0] ks_word;
  logic [63:0] byte_mask;
  logic [3:0]  count_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      key      <= '0;
      nonce_lo <= '0;
      nonce_hi <= '0;
      init_ctr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cc20_pkg::REG_KEY_0_7:    key[0]   <= cfg_data;
        cc20_pkg::REG_KEY_8_15:   key[1]   <= cfg_data;
        cc20_pkg::REG_KEY_16_23:  key[2]   <= cfg_data;
        cc20_pkg::REG_KEY_24_31:  key[3]   <= cfg_data;
        cc20_pkg::REG_NONCE_0_7:  nonce_lo <= cfg_data;
        cc20_pkg::REG_NONCE_8_11: nonce_hi <= cfg_data[31:0];
        cc20_pkg::REG_INIT_CTR:   init_ctr <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Block input words; the counter word comes straight from the config
  // register on a start item, since the counter register loads at that edge.
  assign ctr_word = (state == cc20_pkg::ST_IDLE && start_req) ? init_ctr : counter;

  always_comb begin
    init_words[0] = cc20_pkg::SIGMA_0;
    init_words[1] = cc20_pkg::SIGMA_1;
    init_words[2] = cc20_pkg::SIGMA_2;
    init_words[3] = cc20_pkg::SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init_words[4 + 2 * i] = key[i][31:0];
      init_words[5 + 2 * i] = key[i][63:32];
    end
    init_words[12] = ctr_word;
    init_words[13] = nonce_lo[31:0];
    init_words[14] = nonce_lo[63:32];
    init_words[15] = nonce_hi;
  end

  cc20_round u_round (
    .w_in  (w),
    .diag  (round_cnt[0]),
    .w_out (w_round)
  );

  assign in_fire    = in_valid && !in_stall;
  assign out_fire   = out_valid && !out_stall;
  assign emit_fire  = (state == cc20_pkg::ST_EMIT) && (!out_valid || out_fire);
  assign need_block = start_req || (pos == 3'd0);

  // sequencer
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      cc20_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = need_block ? cc20_pkg::ST_ROUND : cc20_pkg::ST_EMIT;
        end
      end
      cc20_pkg::ST_ROUND: begin
        if (round_cnt == 5'(cc20_pkg::NUM_ROUNDS - 1)) begin
          state_next = cc20_pkg::ST_FINAL;
        end
      end
      cc20_pkg::ST_FINAL: begin
        state_next = cc20_pkg::ST_EMIT;
      end
      cc20_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_next = cc20_pkg::ST_IDLE;
        end
      end
      default: state_next = cc20_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cc20_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counter, position, round count
  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      pos       <= '0;
      round_cnt <= '0;
    end else begin
      if (in_fire) begin
        round_cnt <= '0;
        if (start_req) begin
          counter <= init_ctr;
          pos     <= '0;
        end
      end
      if (state == cc20_pkg::ST_ROUND) begin
        round_cnt <= round_cnt + 5'd1;
      end
      if (state == cc20_pkg::ST_FINAL) begin
        counter <= counter + 32'd1;
      end
      if (emit_fire) begin
        pos <= item_last ? 3'd0 : pos + 3'd1;
      end
    end
  end

  // working state: load, round, feed-forward add
  always_ff @(posedge clk) begin
    if (in_fire && need_block) begin
      w <= init_words;
    end else if (state == cc20_pkg::ST_ROUND) begin
      w <= w_round;
    end else if (state == cc20_pkg::ST_FINAL) begin
      for (int i = 0; i < cc20_pkg::NUM_WORDS; i++) begin
        w[i] <= w[i] + init_words[i];
      end
    end
  end

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_data    <= data_in;
      item_count   <= byte_count;
      item_last    <= last_item;
      item_ks_only <= keystream_only;
    end
  end

  // select keystream word and mask bytes beyond the count
  assign ks_word   = {w[{pos, 1'b1}], w[{pos, 1'b0}]};
  assign count_eff = (item_count > 4'd8) ? 4'd8 : item_count;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[8 * i +: 8] = (4'(i) < count_eff) ? 8'hff : 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      data_out       <= ((item_ks_only ? 64'd0 : item_data) ^ ks_word) & byte_mask;
      byte_count_out <= item_count;
      last_out       <= item_last;
    end
  end

`ifndef SYNTHESIS
  a_final_after_rounds: assert property (@(posedge clk) disable iff (rst)
    state == cc20_pkg::ST_FINAL |->
      $past(state) == cc20_pkg::ST_ROUND &&
      $past(round_cnt) == 5'(cc20_pkg::NUM_ROUNDS - 1))
    else $error("feed-forward add entered without a full set of rounds");

  a_mid_block_skips_rounds: assert property (@(posedge clk) disable iff (rst)
    in_fire && !start_req && pos != 3'd0 |=> state == cc20_pkg::ST_EMIT)
    else $error("mid-block item started a new keystream block");

  a_counter_advance: assert property (@(posedge clk) disable iff (rst)
    state == cc20_pkg::ST_FINAL |=> counter == $past(counter) + 32'd1)
    else $error("block counter did not advance after a block");

  a_last_resets_pos: assert property (@(posedge clk) disable iff (rst)
    emit_fire && item_last |=> pos == 3'd0 && out_valid)
    else $error("word position not cleared after last item");
`endif

endmodule
`default_nettype wire
